/* hdl/positional_insert_delete_list_core_macros.svh */
// Assertion helpers, clocked on clk and held off during reset.
`ifndef POSITIONAL_INSERT_DELETE_LIST_CORE_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_CORE_MACROS_SVH

`define PIDL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define PIDL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/pidl_pkg.sv */
package pidl_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;

	localparam int CMD_W  = 2;
	localparam int POS_W  = 5;
	localparam int VIN_W  = 32;
	localparam int VOUT_W = 32;
	localparam int STAT_W = 2;
	localparam int LENO_W = 5;

	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [CMP_W-1:0]       cmp_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cell control word
	typedef struct packed {
		logic   load_new;
		logic   shift_up;
		logic   shift_down;
		logic   rd_sel;
		value_t new_value;
	} cell_op_t;

endpackage

/* hdl/pidl_cmd_if.sv */
interface pidl_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [pidl_pkg::CMD_W-1:0] command;
	logic [pidl_pkg::POS_W-1:0] position;
	logic [pidl_pkg::VIN_W-1:0] value_in;

	modport source(output valid, command, position, value_in, input ready);
	modport sink(input valid, command, position, value_in, output ready);
endinterface

/* hdl/pidl_rsp_if.sv */
interface pidl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pidl_pkg::VOUT_W-1:0] value_out;
	logic [pidl_pkg::STAT_W-1:0] status;
	logic [pidl_pkg::LENO_W-1:0] length_now;

	modport source(output valid, value_out, status, length_now, input ready);
	modport sink(input valid, value_out, status, length_now, output ready);
endinterface

/* hdl/pidl_cell.sv */
module pidl_cell (
	input  logic               clk,
	input  pidl_pkg::cell_op_t op,
	input  pidl_pkg::value_t   below,
	input  pidl_pkg::value_t   above,
	output pidl_pkg::value_t   data,
	output pidl_pkg::value_t   rd_data
);

	pidl_pkg::value_t data_q;

	always_ff @(posedge clk) begin
		if (op.load_new) begin
			data_q <= op.new_value;
		end else if (op.shift_up) begin
			data_q <= below;
		end else if (op.shift_down) begin
			data_q <= above;
		end
	end

	assign data    = data_q;
	assign rd_data = op.rd_sel ? data_q : '0;

endmodule

/* hdl/positional_insert_delete_list_core.sv */
// Channel  Dir  Fields                               Transaction
// cmd      in   command, position, value_in          valid && ready
// rsp      out  value_out, status, length_now        valid && ready
//
// One command per cycle while cmd.ready is high; cells at and above the position shift on insert/delete.
// Each command yields one result in the output register on the next cycle.
// cmd.ready is high while the output register is empty or being drained.
// Reset clears the length and the output valid; cell contents stay unknown.
`include "positional_insert_delete_list_core_macros.svh"

module positional_insert_delete_list_core (
	input  logic         clk,
	input  logic         arst_n,
	pidl_cmd_if.sink     cmd,
	pidl_rsp_if.source   rsp
);

	pidl_pkg::len_t   len_q;
	pidl_pkg::len_t   len_next;
	pidl_pkg::len_t   len_inc;
	logic             rsp_valid_q;
	pidl_pkg::value_t rsp_value_q;
	pidl_pkg::status_t rsp_status_q;
	pidl_pkg::len_t   rsp_len_q;

	logic              take;
	logic              take_rej;
	pidl_pkg::cmp_t    pos_c;
	pidl_pkg::cmp_t    len_c;
	logic              do_ins;
	logic              do_del;
	logic              do_rd;
	pidl_pkg::status_t stat;
	pidl_pkg::value_t  new_value;
	pidl_pkg::value_t  rd_value;

	pidl_pkg::value_t   cell_data [pidl_pkg::CAPACITY];
	pidl_pkg::value_t   cell_rd   [pidl_pkg::CAPACITY];
	pidl_pkg::cell_op_t cell_op   [pidl_pkg::CAPACITY];

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign take      = cmd.valid && cmd.ready;
	assign take_rej  = take && (stat != pidl_pkg::ST_OK);
	assign pos_c     = pidl_pkg::CMP_W'(cmd.position);
	assign len_c     = pidl_pkg::CMP_W'(len_q);
	assign len_inc   = len_q + pidl_pkg::LEN_W'(1);
	assign new_value = pidl_pkg::VALUE_WIDTH'(cmd.value_in);

	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		do_rd  = 1'b0;
		stat   = pidl_pkg::ST_RANGE;
		unique case (cmd.command) inside
			pidl_pkg::CMD_INSERT: begin
				if (pos_c > len_c) begin
					stat = pidl_pkg::ST_RANGE;
				end else if (len_c >= pidl_pkg::CMP_W'(pidl_pkg::CAPACITY)) begin
					stat = pidl_pkg::ST_FULL;
				end else begin
					stat   = pidl_pkg::ST_OK;
					do_ins = 1'b1;
				end
			end
			pidl_pkg::CMD_READ, pidl_pkg::CMD_DELETE: begin
				if (pos_c < len_c) begin
					stat   = pidl_pkg::ST_OK;
					do_rd  = 1'b1;
					do_del = (cmd.command == pidl_pkg::CMD_DELETE);
				end
			end
			default: begin
				stat = pidl_pkg::ST_RANGE;
			end
		endcase
	end

	always_comb begin
		len_next = len_q;
		if (take && do_ins) begin
			len_next = len_inc;
		end else if (take && do_del) begin
			len_next = len_q - pidl_pkg::LEN_W'(1);
		end
	end

	for (genvar i = 0; i < pidl_pkg::CAPACITY; i++) begin : g_cell
		pidl_pkg::cmp_t   idx;
		pidl_pkg::value_t below;
		pidl_pkg::value_t above;

		assign idx = pidl_pkg::CMP_W'(i);

		always_comb begin
			cell_op[i].load_new   = take && do_ins && (idx == pos_c);
			cell_op[i].shift_up   = take && do_ins && (idx > pos_c);
			cell_op[i].shift_down = take && do_del && (idx >= pos_c);
			cell_op[i].rd_sel     = do_rd && (idx == pos_c);
			cell_op[i].new_value  = new_value;
		end

		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_mid_lo
			assign below = cell_data[i-1];
		end
		if (i == pidl_pkg::CAPACITY - 1) begin : g_last
			assign above = '0;
		end else begin : g_mid_hi
			assign above = cell_data[i+1];
		end

		pidl_cell u_cell (
			.clk     (clk),
			.op      (cell_op[i]),
			.below   (below),
			.above   (above),
			.data    (cell_data[i]),
			.rd_data (cell_rd[i])
		);
	end

	always_comb begin
		rd_value = '0;
		for (int k = 0; k < pidl_pkg::CAPACITY; k++) begin
			rd_value = rd_value | cell_rd[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			len_q <= len_next;
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_value_q  <= rd_value;
			rsp_status_q <= stat;
			rsp_len_q    <= len_next;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.value_out  = pidl_pkg::VOUT_W'(rsp_value_q);
	assign rsp.status     = rsp_status_q;
	assign rsp.length_now = pidl_pkg::LENO_W'(rsp_len_q);

	`PIDL_ASSERT(a_len_bound, len_q <= pidl_pkg::LEN_W'(pidl_pkg::CAPACITY), "length overflow")
	`PIDL_ASSERT_NEXT(a_ins_len, take && do_ins, len_q == $past(len_inc), "insert kept length")
	`PIDL_ASSERT_NEXT(a_rsp_len, take, rsp_len_q == len_q, "reported length differs")
	`PIDL_ASSERT_NEXT(a_rej_hold, take_rej, len_q == $past(len_q), "reject changed length")

endmodule
